/* src/lattice_boltzmann_cell_collision_defines.svh */
// Assertion macros shared by the collision block RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef LATTICE_BOLTZMANN_CELL_COLLISION_DEFINES_SVH
`define LATTICE_BOLTZMANN_CELL_COLLISION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lbm_pkg.sv */
// Types, constants and helper functions for the D2Q9 collision pipeline.
// Depends on nothing; imported by every module of the block except lbm_delay.
`default_nettype none
package lbm_pkg;

	localparam int NDIR  = 9;
	localparam int MW    = 35;
	localparam int QBITS = 31;
	localparam int DIV_LAT = QBITS + 2;
	localparam int EQ_LAT  = 8;
	localparam int RATE_W  = 30;
	localparam logic [RATE_W-1:0] RATE_RESET = 30'd462819751;

	localparam int RECIP_SHIFT = 34;
	localparam logic [30:0] RECIP_9  = 31'((64'd1 << RECIP_SHIFT) / 64'd9);
	localparam logic [30:0] RECIP_36 = 31'((64'd1 << RECIP_SHIFT) / 64'd36);

	localparam int DIR_X [NDIR] = '{1, 1, 1, 0, 0, 0, -1, -1, -1};
	localparam int DIR_Y [NDIR] = '{1, 0, -1, 1, 0, -1, 1, 0, -1};
	localparam int W_NUM [NDIR] = '{1, 1, 1, 1, 4, 1, 1, 1, 1};
	localparam int W_DEN [NDIR] = '{36, 9, 36, 9, 9, 9, 36, 9, 36};
	localparam logic [30:0] W_RECIP [NDIR] = '{RECIP_36, RECIP_9, RECIP_36, RECIP_9,
		RECIP_9, RECIP_9, RECIP_36, RECIP_9, RECIP_36};

	typedef logic signed [31:0] word_t;
	typedef word_t [NDIR-1:0] dist_t;
	typedef logic signed [MW-1:0] moment_t;

	typedef struct packed {
		logic  solid;
		dist_t f;
		word_t rho;
	} node_t;

	function automatic word_t sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return word_t'(x);
	endfunction

endpackage
`default_nettype wire

/* src/lattice_boltzmann_cell_collision.sv */
// Top level of the D2Q9 BGK collision block: moments, dividers, equilibrium pipeline.
// Depends on lbm_pkg, lbm_moments, lbm_div, lbm_delay, lbm_equil and the defines header.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = f_in_0..f_in_8, s_tuser = solid
// m_*       out  m_tvalid/m_tready  m_tdata = f_out_0..f_out_8, density, vel_x, vel_y
// cfg_*     in   cfg_wr_en          cfg_wr_data = relaxation_rate
//
// One node enters per cycle while the output is not stalled; each node passes through the
// moment stage, the one-bit-per-stage velocity divider and the eight-stage equilibrium pipeline.
// Reset clears all valid bits and loads the default relaxation rate.
// When a result waits at the output, the whole pipeline holds and s_tready is low.
`default_nettype none
`include "lattice_boltzmann_cell_collision_defines.svh"
module lattice_boltzmann_cell_collision
	import lbm_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// f_in_0 .. f_in_8, 32 bits each, from the lowest bit up.
	input  wire logic [287:0]      s_tdata,
	// solid.
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// f_out_0 .. f_out_8, density, vel_x, vel_y, 32 bits each, from the lowest bit up.
	output logic [383:0]           m_tdata,
	input  wire logic              cfg_wr_en,
	input  wire logic [RATE_W-1:0] cfg_wr_data
);

	logic              pipe_en;
	logic [RATE_W-1:0] rate_q;

	logic    mom_valid;
	node_t   mom_node;
	moment_t mx, my;

	word_t ux, uy;
	logic  dly_valid;
	node_t dly_node;

	dist_t f_out;
	word_t density, vel_x, vel_y;

	assign pipe_en  = !m_tvalid || m_tready;
	assign s_tready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_wr_en) begin
			rate_q <= cfg_wr_data;
		end
	end

	lbm_moments u_moments (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (s_tvalid),
		.f        (dist_t'(s_tdata)),
		.solid    (s_tuser),
		.valid    (mom_valid),
		.node     (mom_node),
		.mx       (mx),
		.my       (my)
	);

	lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk (clk),
		.en  (pipe_en),
		.m   (mx),
		.rho (mom_node.rho),
		.u   (ux)
	);

	lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk (clk),
		.en  (pipe_en),
		.m   (my),
		.rho (mom_node.rho),
		.u   (uy)
	);

	lbm_delay #(.WIDTH($bits(node_t)), .DEPTH(DIV_LAT)) u_delay (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (mom_valid),
		.in_data   (mom_node),
		.out_valid (dly_valid),
		.out_data  (dly_node)
	);

	lbm_equil #(.FRAC_BITS(FRAC_BITS)) u_equil (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (dly_valid),
		.node      (dly_node),
		.ux        (ux),
		.uy        (uy),
		.omega     (rate_q),
		.out_valid (m_tvalid),
		.f_out     (f_out),
		.rho       (density),
		.vel_x     (vel_x),
		.vel_y     (vel_y)
	);

	assign m_tdata = {vel_y, vel_x, density, f_out};

	`LBM_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
		"Input request taken while the output is stalled.")
	`LBM_ASSERT_NOW(a_zero_velocity, m_tvalid && (density[31] || density == 32'sd0),
		vel_x == 32'sd0 && vel_y == 32'sd0, "Nonzero velocity at nonpositive density.")
	`LBM_ASSERT_NEXT(a_mid_pipe_frozen, !pipe_en, $stable(dly_valid),
		"Pipeline moved while the output was stalled.")

endmodule
`default_nettype wire

/* src/lbm_moments.sv */
// First pipeline stage: density and the two momentum sums of one node.
// Depends on lbm_pkg.
`default_nettype none
module lbm_moments
	import lbm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    in_valid,
	input  wire dist_t   f,
	input  wire logic    solid,
	output logic         valid,
	output node_t        node,
	output moment_t      mx,
	output moment_t      my
);

	logic        v_s1;
	node_t       node_s1;
	moment_t     mx_s1;
	moment_t     my_s1;
	logic signed [35:0] sum;

	assign sum = 36'(f[0]) + 36'(f[1]) + 36'(f[2]) + 36'(f[3]) + 36'(f[4])
		+ 36'(f[5]) + 36'(f[6]) + 36'(f[7]) + 36'(f[8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_s1.solid <= solid;
			node_s1.f     <= f;
			node_s1.rho   <= sat32(64'(sum));
			mx_s1 <= MW'(f[0]) + MW'(f[1]) + MW'(f[2]) - MW'(f[6]) - MW'(f[7]) - MW'(f[8]);
			my_s1 <= MW'(f[0]) + MW'(f[3]) + MW'(f[6]) - MW'(f[2]) - MW'(f[5]) - MW'(f[8]);
		end
	end

	assign valid = v_s1;
	assign node  = node_s1;
	assign mx    = mx_s1;
	assign my    = my_s1;

endmodule
`default_nettype wire

/* src/lbm_div.sv */
// Pipelined restoring divider for one velocity component, one quotient bit per stage.
// Depends on lbm_pkg.
`default_nettype none
module lbm_div
	import lbm_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  wire logic    clk,
	input  wire logic    en,
	input  wire moment_t m,
	input  wire word_t   rho,
	output word_t        u
);

	localparam int NW = MW - 1 + FRAC_BITS;
	localparam int RW = 2 * QBITS;
	localparam int CW = (NW > RW) ? NW : RW;

	logic [MW-2:0]   mag;
	logic [CW-1:0]   num;
	logic [CW-1:0]   lim;

	logic [CW-1:0]    rem_s [QBITS+1];
	logic [QBITS-1:0] quo_s [QBITS+1];
	logic [QBITS-1:0] dv_s  [QBITS+1];
	logic             neg_s [QBITS+1];
	logic             ovf_s [QBITS+1];
	logic             zero_s [QBITS+1];

	logic [CW-1:0] dsh [QBITS];
	logic          ge  [QBITS];
	word_t         qx;
	word_t         u_q;

	assign mag = (MW-1)'(m[MW-1] ? -m : m);
	assign num = CW'(mag) << FRAC_BITS;
	assign lim = CW'(rho[QBITS-1:0]) << QBITS;

	always_comb begin
		for (int k = 0; k < QBITS; k++) begin
			dsh[k] = CW'(dv_s[k]) << (QBITS - 1 - k);
			ge[k]  = rem_s[k] >= dsh[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			quo_s[0]  <= '0;
			dv_s[0]   <= rho[QBITS-1:0];
			neg_s[0]  <= m[MW-1];
			ovf_s[0]  <= num >= lim;
			zero_s[0] <= rho[31] || (rho == 32'sd0);
			for (int k = 0; k < QBITS; k++) begin
				rem_s[k+1]  <= ge[k] ? rem_s[k] - dsh[k] : rem_s[k];
				quo_s[k+1]  <= quo_s[k] | (QBITS'(ge[k]) << (QBITS - 1 - k));
				dv_s[k+1]   <= dv_s[k];
				neg_s[k+1]  <= neg_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	assign qx = {1'b0, quo_s[QBITS]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[QBITS]) begin
				u_q <= 32'sd0;
			end else if (ovf_s[QBITS]) begin
				u_q <= neg_s[QBITS] ? 32'sh80000000 : 32'sh7fffffff;
			end else begin
				u_q <= neg_s[QBITS] ? -qx : qx;
			end
		end
	end

	assign u = u_q;

endmodule
`default_nettype wire

/* src/lbm_delay.sv */
// Delay line with valid bits that keeps node data aligned with the divider.
// Depends on nothing beyond its parameters.
`default_nettype none
module lbm_delay #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	output logic [WIDTH-1:0]      out_data
);

	logic [DEPTH-1:0] vld_s;
	logic [WIDTH-1:0] dat_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= DEPTH'({vld_s, in_valid});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s[0] <= in_data;
			for (int k = 1; k < DEPTH; k++) begin
				dat_s[k] <= dat_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_data  = dat_s[DEPTH-1];

endmodule
`default_nettype wire

/* src/lbm_equil.sv */
// Equilibrium and BGK relaxation pipeline, eight stages, with bounce-back at solid nodes.
// Depends on lbm_pkg.
`default_nettype none
module lbm_equil
	import lbm_pkg::*;
#(
	parameter int FRAC_BITS = 28
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire node_t             node,
	input  wire word_t             ux,
	input  wire word_t             uy,
	input  wire logic [RATE_W-1:0] omega,
	output logic                   out_valid,
	output dist_t                  f_out,
	output word_t                  rho,
	output word_t                  vel_x,
	output word_t                  vel_y
);

	typedef struct packed {
		node_t node;
		word_t ux;
		word_t uy;
	} eq_ctx_t;

	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

	logic [EQ_LAT-1:0] v_s;
	eq_ctx_t           ctx_s [EQ_LAT];

	logic signed [63:0] pxx, pyy;
	logic signed [33:0] dot_c [NDIR];
	word_t              vu_c  [NDIR];
	word_t              sqx_s1, sqy_s1;
	word_t              vu_s1 [NDIR];

	logic signed [33:0] sumsq;
	logic signed [63:0] vv_c [NDIR];
	word_t              usqr_s2;
	word_t              vu_s2   [NDIR];
	word_t              half_s2 [NDIR];

	word_t              poly_s3 [NDIR];

	logic signed [63:0] rp_c [NDIR];
	word_t              p_s4 [NDIR];

	logic signed [34:0] t_c  [NDIR];
	logic [33:0]        a_c  [NDIR];
	logic [64:0]        qp_c [NDIR];
	logic [33:0]        a_s5  [NDIR];
	logic [30:0]        qe_s5 [NDIR];
	logic               neg_s5 [NDIR];

	logic [33:0]        r_c [NDIR];
	logic [31:0]        q_c [NDIR];
	word_t              eq_s6 [NDIR];

	logic signed [32:0] diff_c [NDIR];
	logic signed [30:0] om;
	logic signed [63:0] prod_s7 [NDIR];

	dist_t              f_out_s8;

	assign pxx = 64'(ux) * 64'(ux);
	assign pyy = 64'(uy) * 64'(uy);
	assign sumsq = 34'(sqx_s1) + 34'(sqy_s1);
	assign om = $signed({1'b0, omega});

	always_comb begin
		for (int c = 0; c < NDIR; c++) begin
			dot_c[c] = ((DIR_X[c] == 1) ? 34'(ux) : (DIR_X[c] == -1) ? -34'(ux) : 34'sd0)
				+ ((DIR_Y[c] == 1) ? 34'(uy) : (DIR_Y[c] == -1) ? -34'(uy) : 34'sd0);
			vu_c[c] = sat32(64'(dot_c[c]) * 64'sd3);
			vv_c[c] = 64'(vu_s1[c]) * 64'(vu_s1[c]);
			rp_c[c] = 64'(ctx_s[2].node.rho) * 64'(poly_s3[c]);
			t_c[c]  = (W_NUM[c] == 4) ? (35'(p_s4[c]) <<< 2) : 35'(p_s4[c]);
			a_c[c]  = t_c[c][34] ? 34'(-t_c[c] + 35'(W_DEN[c] - 1)) : 34'(t_c[c]);
			qp_c[c] = 65'(a_c[c]) * 65'(W_RECIP[c]);
			r_c[c]  = a_s5[c] - 34'(qe_s5[c]) * 34'(W_DEN[c]);
			q_c[c]  = 32'(qe_s5[c]) + 32'(r_c[c] >= 34'(W_DEN[c]));
			diff_c[c] = 33'(ctx_s[5].node.f[c]) - 33'(eq_s6[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= EQ_LAT'({v_s, in_valid});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= '{node: node, ux: ux, uy: uy};
			for (int k = 1; k < EQ_LAT; k++) begin
				ctx_s[k] <= ctx_s[k-1];
			end
			sqx_s1  <= sat32(pxx >>> FRAC_BITS);
			sqy_s1  <= sat32(pyy >>> FRAC_BITS);
			usqr_s2 <= sat32((64'(sumsq) * 64'sd3) >>> 1);
			for (int c = 0; c < NDIR; c++) begin
				vu_s1[c]   <= vu_c[c];
				vu_s2[c]   <= vu_s1[c];
				half_s2[c] <= sat32(vv_c[c] >>> (FRAC_BITS + 1));
				poly_s3[c] <= sat32(ONE + 64'(vu_s2[c]) + 64'(half_s2[c]) - 64'(usqr_s2));
				p_s4[c]    <= sat32(rp_c[c] >>> FRAC_BITS);
				a_s5[c]    <= a_c[c];
				qe_s5[c]   <= 31'(qp_c[c] >> RECIP_SHIFT);
				neg_s5[c]  <= t_c[c][34];
				eq_s6[c]   <= neg_s5[c] ? -word_t'(q_c[c]) : word_t'(q_c[c]);
				prod_s7[c] <= 64'(om) * 64'(diff_c[c]);
				f_out_s8[c] <= ctx_s[6].node.solid ? ctx_s[6].node.f[NDIR-1-c]
					: sat32(64'(ctx_s[6].node.f[c]) - (prod_s7[c] >>> FRAC_BITS));
			end
		end
	end

	assign out_valid = v_s[EQ_LAT-1];
	assign f_out     = f_out_s8;
	assign rho       = ctx_s[EQ_LAT-1].node.rho;
	assign vel_x     = ctx_s[EQ_LAT-1].ux;
	assign vel_y     = ctx_s[EQ_LAT-1].uy;

endmodule
`default_nettype wire
